/* sv/sctp_pkg.sv */
package sctp_pkg;

    typedef enum logic [3:0] {
        C_S,
        C_E,
        C_T,
        C_R,
        C_L,
        C_A,
        C_Y,
        C_O,
        C_N,
        C_F,
        C_1,
        C_2,
        C_3,
        C_4,
        C_OTHER,
        C_BLANK
    } t_class;

    typedef enum logic [1:0] {
        SLOT_SET,
        SLOT_RELAY,
        SLOT_DIGIT,
        SLOT_STATE
    } t_slot;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam logic [3:0] DRIVE_OFF = 4'hF;
    localparam logic [2:0] IDX_MAX   = 3'd7;

    typedef struct packed {
        logic       status;
        logic [3:0] drive;
    } t_result;

    function automatic t_class classify(input logic [7:0] c);
        t_class cls;
        cls = C_OTHER;
        if (c inside {8'h20, [8'h09:8'h0D]}) begin
            cls = C_BLANK;
        end else begin
            case (c)
                "s": cls = C_S;
                "e": cls = C_E;
                "t": cls = C_T;
                "r": cls = C_R;
                "l": cls = C_L;
                "a": cls = C_A;
                "y": cls = C_Y;
                "o": cls = C_O;
                "n": cls = C_N;
                "f": cls = C_F;
                "1": cls = C_1;
                "2": cls = C_2;
                "3": cls = C_3;
                "4": cls = C_4;
                default: cls = C_OTHER;
            endcase
        end
        return cls;
    endfunction

    function automatic logic [3:0] slot_mask(input t_slot s);
        logic [3:0] m;
        case (s)
            SLOT_SET:   m = 4'b0001;
            SLOT_RELAY: m = 4'b0001;
            SLOT_DIGIT: m = 4'b1111;
            SLOT_STATE: m = 4'b0011;
            default:    m = 4'b0000;
        endcase
        return m;
    endfunction

    function automatic logic [2:0] word_len(input t_slot s, input logic [1:0] k);
        logic [2:0] len;
        len = 3'd0;
        case (s)
            SLOT_SET:   len = (k == 2'd0) ? 3'd3 : 3'd0;
            SLOT_RELAY: len = (k == 2'd0) ? 3'd5 : 3'd0;
            SLOT_DIGIT: len = 3'd1;
            SLOT_STATE: begin
                case (k)
                    2'd0:    len = 3'd2;
                    2'd1:    len = 3'd3;
                    default: len = 3'd0;
                endcase
            end
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Expected class of a character; C_BLANK stands for no character, which never matches.
    function automatic t_class word_class(input t_slot s, input logic [1:0] k,
                                          input logic [2:0] idx);
        t_class cls;
        cls = C_BLANK;
        case (s)
            SLOT_SET: begin
                if (k == 2'd0) begin
                    case (idx)
                        3'd0:    cls = C_S;
                        3'd1:    cls = C_E;
                        3'd2:    cls = C_T;
                        default: cls = C_BLANK;
                    endcase
                end
            end
            SLOT_RELAY: begin
                if (k == 2'd0) begin
                    case (idx)
                        3'd0:    cls = C_R;
                        3'd1:    cls = C_E;
                        3'd2:    cls = C_L;
                        3'd3:    cls = C_A;
                        3'd4:    cls = C_Y;
                        default: cls = C_BLANK;
                    endcase
                end
            end
            SLOT_DIGIT: begin
                if (idx == 3'd0) begin
                    case (k)
                        2'd0:    cls = C_1;
                        2'd1:    cls = C_2;
                        2'd2:    cls = C_3;
                        default: cls = C_4;
                    endcase
                end
            end
            SLOT_STATE: begin
                case (k)
                    2'd0: begin
                        case (idx)
                            3'd0:    cls = C_O;
                            3'd1:    cls = C_N;
                            default: cls = C_BLANK;
                        endcase
                    end
                    2'd1: begin
                        case (idx)
                            3'd0:    cls = C_O;
                            3'd1:    cls = C_F;
                            3'd2:    cls = C_F;
                            default: cls = C_BLANK;
                        endcase
                    end
                    default: cls = C_BLANK;
                endcase
            end
            default: cls = C_BLANK;
        endcase
        return cls;
    endfunction

endpackage

/* sv/switch_command_text_parser_unit.sv */
// Command text parser for a four-output switch block.
// Input channel: one character per request on i_char_code, taken when push is
// high and full is low. Whitespace splits the text into tokens, and the command
// "set relay <1..4> on|off" drives the chosen line of o_drive_lines low or high.
// Result channel: while empty is low, o_status (0 ok, 1 error) and
// o_drive_lines show the oldest result; pop takes it. A result is given only
// when the whitespace after the fourth token, or after a mismatching token,
// arrives; other characters give none.
// A result passes the front stage, the character queue and the matcher into the
// result queue. Throughput: one character per cycle while full stays low.
// A classifying front stage and the matcher are joined by a queue of CMD_DEPTH
// entries, and results wait in a queue of RES_DEPTH entries, so characters keep
// flowing while a result waits to be popped; full rises only when both queues
// and the front stage are occupied.
// Reset (synchronous, active low) empties both queues, restarts parsing at the
// first token and sets all four drive lines high.
module switch_command_text_parser_unit #(
    parameter int CMD_DEPTH = 4,
    parameter int RES_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic       o_status,
    output logic [3:0] o_drive_lines
);
    import sctp_pkg::*;

    localparam int ClsW = $bits(t_class);
    localparam int ResW = $bits(t_result);

    logic            front_valid;
    t_class          front_class;
    logic            cmd_full;
    logic            cmd_empty;
    logic [ClsW-1:0] cmd_data;
    logic            cmd_pop;
    logic            res_full;
    logic            res_push;
    t_result         res_in;
    logic [ResW-1:0] res_q;
    t_result         res_out;

    sctp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_char_code (i_char_code),
        .o_valid     (front_valid),
        .o_class     (front_class),
        .i_ready     (!cmd_full)
    );

    sctp_fifo #(
        .Width (ClsW),
        .Depth (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_class),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_data),
        .o_empty (cmd_empty)
    );

    sctp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!cmd_empty),
        .i_class    (t_class'(cmd_data)),
        .o_pop      (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    sctp_fifo #(
        .Width (ResW),
        .Depth (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign res_out       = t_result'(res_q);
    assign o_status      = res_out.status;
    assign o_drive_lines = res_out.drive;

`ifndef SYNTHESIS
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("Result written into a full result queue.");

    a_res_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> (cmd_pop && !cmd_empty))
        else $error("Result produced without a queued character.");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (empty && !full))
        else $error("Queues not cleared by reset.");
`endif

endmodule

/* sv/sctp_fifo.sv */
module sctp_fifo #(
    parameter int Width = 4,
    parameter int Depth = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [Width-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [Width-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(Depth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* sv/sctp_front.sv */
module sctp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_char_code,
    output logic              o_valid,
    output sctp_pkg::t_class  o_class,
    input  logic              i_ready
);
    import sctp_pkg::*;

    logic   r_valid;
    t_class r_class;
    logic   take;

    assign o_full  = r_valid && !i_ready;
    assign take    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_class = r_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_class <= classify(i_char_code);
        end
    end

endmodule

/* sv/sctp_back.sv */
module sctp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sctp_pkg::t_class  i_class,
    output logic              o_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output sctp_pkg::t_result o_res
);
    import sctp_pkg::*;

    t_slot      r_slot, n_slot;
    logic [2:0] r_idx, n_idx;
    logic [3:0] r_flags, n_flags;
    logic       r_inside, n_inside;
    logic [1:0] r_chosen, n_chosen;
    logic [3:0] r_drive, n_drive;

    logic [2:0] idx;
    logic [3:0] flags;
    logic       found;
    logic [1:0] hit;

    always_comb begin
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_flags    = r_flags;
        n_inside   = r_inside;
        n_chosen   = r_chosen;
        n_drive    = r_drive;
        o_pop      = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{status: ST_OK, drive: r_drive};
        idx        = r_inside ? r_idx : 3'd0;
        flags      = r_inside ? r_flags : slot_mask(r_slot);
        found      = 1'b0;
        hit        = 2'd0;
        if (i_valid && !i_res_full) begin
            o_pop = 1'b1;
            if (i_class != C_BLANK) begin
                for (int k = 0; k < 4; k++) begin
                    if (flags[k] && !(idx < word_len(r_slot, 2'(k))
                            && word_class(r_slot, 2'(k), idx) == i_class)) begin
                        flags[k] = 1'b0;
                    end
                end
                n_inside = 1'b1;
                n_flags  = flags;
                n_idx    = (idx == IDX_MAX) ? IDX_MAX : idx + 1'b1;
            end else if (r_inside) begin
                for (int k = 0; k < 4; k++) begin
                    if (!found && r_flags[k] && word_len(r_slot, 2'(k)) == r_idx) begin
                        found = 1'b1;
                        hit   = 2'(k);
                    end
                end
                n_inside = 1'b0;
                n_flags  = '0;
                n_idx    = '0;
                if (!found) begin
                    n_slot     = SLOT_SET;
                    o_res_push = 1'b1;
                    o_res      = '{status: ST_ERR, drive: r_drive};
                end else if (r_slot != SLOT_STATE) begin
                    if (r_slot == SLOT_DIGIT) begin
                        n_chosen = hit;
                    end
                    n_slot = t_slot'(r_slot + 1'b1);
                end else begin
                    if (hit == 2'd0) begin
                        n_drive = r_drive & ~(4'b0001 << r_chosen);
                    end else begin
                        n_drive = r_drive | (4'b0001 << r_chosen);
                    end
                    n_slot     = SLOT_SET;
                    o_res_push = 1'b1;
                    o_res      = '{status: ST_OK, drive: n_drive};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= SLOT_SET;
            r_idx    <= '0;
            r_flags  <= '0;
            r_inside <= 1'b0;
            r_chosen <= '0;
            r_drive  <= DRIVE_OFF;
        end else begin
            r_slot   <= n_slot;
            r_idx    <= n_idx;
            r_flags  <= n_flags;
            r_inside <= n_inside;
            r_chosen <= n_chosen;
            r_drive  <= n_drive;
        end
    end

endmodule

/* dv/tb_switch_command_text_parser_unit.sv */
`timescale 1ns / 100ps

module tb_switch_command_text_parser_unit;
    import sctp_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 270;

    typedef struct {
        logic [7:0] code;
        bit         typed;
        t_result    want;
    } t_text_row;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       push          = 1'b0;
    logic [7:0] i_char_code   = 8'h00;
    logic       pop           = 1'b0;
    logic       full;
    logic       empty;
    logic       o_status;
    logic [3:0] o_drive_lines;

    switch_command_text_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_char_code   (i_char_code),
        .empty         (empty),
        .pop           (pop),
        .o_status      (o_status),
        .o_drive_lines (o_drive_lines)
    );

    string vocab [4][4] = '{
        '{"set", "", "", ""},
        '{"relay", "", "", ""},
        '{"1", "2", "3", "4"},
        '{"on", "off", "", ""}
    };
    logic [7:0] blank_codes [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    t_slot      cmd_slot    = SLOT_SET;
    logic [2:0] tok_pos     = 3'd0;
    logic [3:0] cand_mask   = 4'b0000;
    logic       in_token    = 1'b0;
    logic [1:0] sel_line    = 2'd0;
    logic [3:0] line_levels = DRIVE_OFF;

    t_result    expected_results [$];
    t_text_row  directed_text [$];
    int         mismatches     = 0;
    int         chars_sent     = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    bit         hold_pending   = 1'b0;
    int         quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advances the parser state by one character and gives the outcome, if any.
    function automatic bit parse_char(input logic [7:0] c, output t_result outcome);
        int hit;
        int len;
        logic [3:0] bit_sel;
        outcome = '{ST_OK, line_levels};
        if (!(c == 8'h20 || (c >= 8'h09 && c <= 8'h0D))) begin
            if (!in_token) begin
                in_token  = 1'b1;
                tok_pos   = 3'd0;
                cand_mask = 4'b0000;
                for (int k = 0; k < 4; k++) begin
                    cand_mask[k] = (vocab[cmd_slot][k].len() != 0);
                end
            end
            for (int k = 0; k < 4; k++) begin
                len = vocab[cmd_slot][k].len();
                if (cand_mask[k] && !(tok_pos < len && vocab[cmd_slot][k][tok_pos] == c)) begin
                    cand_mask[k] = 1'b0;
                end
            end
            if (tok_pos < IDX_MAX) begin
                tok_pos = tok_pos + 3'd1;
            end
            return 1'b0;
        end
        if (!in_token) begin
            return 1'b0;
        end
        in_token = 1'b0;
        hit = -1;
        for (int k = 0; k < 4; k++) begin
            if (hit < 0 && cand_mask[k] && vocab[cmd_slot][k].len() == tok_pos) begin
                hit = k;
            end
        end
        cand_mask = 4'b0000;
        tok_pos   = 3'd0;
        if (hit < 0) begin
            cmd_slot = SLOT_SET;
            outcome  = '{ST_ERR, line_levels};
            return 1'b1;
        end
        if (cmd_slot == SLOT_DIGIT) begin
            sel_line = hit[1:0];
        end
        if (cmd_slot != SLOT_STATE) begin
            cmd_slot = cmd_slot.next();
            return 1'b0;
        end
        bit_sel = 4'b0001 << sel_line;
        if (hit == 0) begin
            line_levels = line_levels & ~bit_sel;
        end else begin
            line_levels = line_levels | bit_sel;
        end
        cmd_slot = SLOT_SET;
        outcome  = '{ST_OK, line_levels};
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                             input t_result want = '{ST_OK, DRIVE_OFF});
        t_result outcome;
        bit      got;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_char_code <= c;
        do @(posedge i_clk); while (full);
        chars_sent++;
        got = parse_char(c, outcome);
        if (typed) begin
            expected_results.push_back(want);
        end else if (got) begin
            expected_results.push_back(outcome);
        end
    endtask

    task automatic send_token(input t_slot s);
        logic [7:0] tok [$];
        string      word;
        int         pick;
        pick = 0;
        if (s == SLOT_DIGIT) begin
            pick = $urandom_range(3);
        end else if (s == SLOT_STATE) begin
            pick = $urandom_range(1);
        end
        word = vocab[s][pick];
        for (int i = 0; i < word.len(); i++) begin
            tok.push_back(word[i]);
        end
        case ($urandom_range(19))
            0: tok[$urandom_range(tok.size() - 1)] = 8'($urandom_range(255));
            1: void'(tok.pop_back());
            2: tok.push_back(word[$urandom_range(word.len() - 1)]);
            3: begin
                tok.delete();
                repeat ($urandom_range(6, 10)) tok.push_back(8'($urandom_range(8'h61, 8'h7A)));
            end
            default: ;
        endcase
        foreach (tok[i]) send_char(tok[i]);
        repeat ($urandom_range(1, 3)) send_char(blank_codes[$urandom_range(5)]);
    endtask

    task automatic add_row(input logic [7:0] c, input bit typed = 1'b0,
                           input t_result want = '{ST_OK, DRIVE_OFF});
        t_text_row row;
        row.code  = c;
        row.typed = typed;
        row.want  = want;
        directed_text.push_back(row);
    endtask

    task automatic add_word(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_row(s[i]);
        end
    endtask

    initial begin : result_side
        t_result want;
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, {o_status, o_drive_lines});
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch("status", want.status, o_status);
                    end
                    if (o_drive_lines !== want.drive) begin
                        report_mismatch("drive lines", want.drive, o_drive_lines);
                    end
                end
            end
            if (hold_pending) begin
                hold_pending = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int send_pcts [4]  = '{0, 51, 0, 38};
        int stall_pcts [4] = '{0, 0, 51, 38};
        int target;

        // A complete command with doubled blanks, then stray bytes at both ends of the
        // code range, then a token long enough to saturate the position counter.
        add_row(8'h20);
        add_word("set");
        add_row(8'h20);
        add_row(8'h20);
        add_word("relay");
        add_row(8'h09);
        add_word("2");
        add_row(8'h0B);
        add_word("on");
        add_row(8'h0A, 1'b1, '{ST_OK, 4'hD});
        add_row(8'h00);
        add_row(8'hFF);
        add_row(8'h0C, 1'b1, '{ST_ERR, 4'hD});
        add_word("zzzzzzzz");
        add_row(8'h0D, 1'b1, '{ST_ERR, 4'hD});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_text[i]) begin
            send_char(directed_text[i].code, directed_text[i].typed, directed_text[i].want);
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = stall_pcts[ph];
            target = chars_sent + PHASE_ITEMS;
            while (chars_sent < target) begin
                if ($urandom_range(9) == 0) begin
                    repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        send_token(t_slot'(i));
                        if ($urandom_range(39) == 0) begin
                            break;
                        end
                    end
                end
            end
        end

        // The receiver holds off while every second request, a blank, closes a bad token,
        // so the result queue backs up and the input side must stall.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_pending   = 1'b1;
        repeat (40) begin
            send_char(8'($urandom_range(8'h61, 8'h7A)));
            send_char(blank_codes[$urandom_range(5)]);
        end

        push <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/sctp_pkg.sv
sv/sctp_fifo.sv
sv/sctp_front.sv
sv/sctp_back.sv
sv/switch_command_text_parser_unit.sv
dv/tb_switch_command_text_parser_unit.sv
